@@ hw/rtl/afr_pkg.sv @@
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types and constants for the API frame receiver and filter.
// ----------------------------------------------------------------------------
`default_nettype none

package afr_pkg;

  // Framing constants
  localparam logic [7:0]  START_BYTE = 8'h7E;
  localparam logic [7:0]  SUM_GOOD   = 8'hFF;
  localparam logic [15:0] FRAME_LEN  = 16'd15;
  localparam logic [7:0]  FRAME_TYPE = 8'h90;

  // Payload positions of interest
  localparam logic [15:0] POS_ADDR_LAST = 16'd8;
  localparam logic [15:0] POS_CMD_FIRST = 16'd12;
  localparam logic [15:0] POS_CMD_LAST  = 16'd14;

  localparam int unsigned NUM_CMD = 3;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SYNC     = 3'd0,
    PH_LEN_HI   = 3'd1,
    PH_LEN_LO   = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_CHECKSUM = 3'd4
  } afr_phase_t;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SUM  = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_BAD_TYPE = 3'd4,
    ST_BAD_ADDR = 3'd5
  } afr_status_t;

  typedef logic [7:0] afr_byte_t;

  // One status beat
  typedef struct packed {
    afr_status_t status;
    logic [15:0] length;
    afr_byte_t   cmd_third;
    afr_byte_t   cmd_second;
    afr_byte_t   cmd_first;
  } afr_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/api_frame_receiver_filter_unit.sv @@
// ----------------------------------------------------------------------------
// api_frame_receiver_filter_unit
// Deframes API frames from a serial byte stream and reports one status
// beat per frame, with the command bytes of the payload.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per beat, in_tdata = rx_byte.
//   out_* : one beat per frame end. out_tuser = frame_status; out_tdata
//           = frame_length, command_first, command_second, command_third.
//   cfg_* : expected sender address, written while the unit is idle.
// Timing:
//   A byte is held in the input register and then parsed into the result
//   register. One byte per cycle is sustained unless a frame-ending byte
//   waits on a full result register; the parser state update is the only
//   per-byte loop.
// Stall:
//   While out_tready is low, bytes that end no frame keep flowing; a byte
//   that ends a frame waits in the input register if the result slot is
//   full, and in_tready holds off further bytes until it moves on.
// Reset:
//   rst_n (synchronous, active low) empties both registers, returns the
//   parser to start-byte search and clears the address register.
// ----------------------------------------------------------------------------
`default_nettype none

module api_frame_receiver_filter_unit
  import afr_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // out_tdata: [15:0] frame_length, [23:16] command_first,
  //            [31:24] command_second, [39:32] command_third
  // out_tuser: [2:0] frame_status
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,
  output logic [2:0]       out_tuser,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data
);

  logic        byte_vld;
  afr_byte_t   byte_data;
  logic        step;
  logic        emit;
  logic        out_free;
  afr_result_t result;
  afr_result_t out_beat;
  logic [63:0] src_addr_r;

  // Expected sender address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r <= '0;
    end else if (cfg_wr_en) begin
      src_addr_r <= cfg_wr_data;
    end
  end

  // Parse the held byte unless it ends a frame and the result slot is full
  assign step = byte_vld && (!emit || out_free);

  afr_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (step),
    .vld       (byte_vld),
    .data      (byte_data)
  );

  afr_parser #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (byte_data),
    .src_addr (src_addr_r),
    .emit     (emit),
    .result   (result)
  );

  afr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && emit),
    .result     (result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_beat   (out_beat)
  );

  // Beat packing
  assign out_tuser = out_beat.status;
  assign out_tdata = {out_beat.cmd_third, out_beat.cmd_second,
                      out_beat.cmd_first, out_beat.length};

endmodule

`default_nettype wire

@@ hw/rtl/afr_in_stage.sv @@
// ----------------------------------------------------------------------------
// afr_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_in_stage
  import afr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire afr_byte_t in_tdata,
  input  wire logic      take,
  output logic           vld,
  output afr_byte_t      data
);

  logic      vld_r, vld_nxt;
  afr_byte_t data_r;

  // Room when empty or when the held byte leaves this cycle
  assign in_tready = !vld_r || take;
  assign vld_nxt   = in_tvalid || (vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

  assign vld  = vld_r;
  assign data = data_r;

endmodule

`default_nettype wire

@@ hw/rtl/afr_parser.sv @@
// ----------------------------------------------------------------------------
// afr_parser
// Frame state machine: deframes, sums, checks type and address, captures
// command bytes and forms the status at each frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_parser
  import afr_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire afr_byte_t   rx_byte,
  input  wire logic [63:0] src_addr,
  output logic             emit,
  output afr_result_t      result
);

  afr_phase_t  phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pos_r, pos_nxt;
  afr_byte_t   sum_r, sum_nxt;
  logic        type_good_r, type_good_nxt;
  logic        addr_good_r, addr_good_nxt;
  afr_byte_t   cmd_r   [NUM_CMD];
  afr_byte_t   cmd_nxt [NUM_CMD];

  logic [15:0] len_full;
  logic        too_long;
  afr_byte_t   sum_add;
  logic [15:0] pos_inc;
  logic [2:0]  addr_sel;
  afr_byte_t   addr_want;
  logic [1:0]  cmd_off;
  afr_status_t chk_status;

  // Shared datapath pieces
  assign len_full  = {len_r[15:8], rx_byte};
  assign too_long  = {1'b0, len_full} > 17'(MAX_LENGTH);
  assign sum_add   = sum_r + rx_byte;
  assign pos_inc   = pos_r + 16'd1;
  // Payload byte 1 maps to address byte 7 (bits 63..56), byte 8 to byte 0
  assign addr_sel  = 3'(4'd8 - pos_r[3:0]);
  assign addr_want = src_addr[{addr_sel, 3'b000} +: 8];
  assign cmd_off   = 2'(pos_r - POS_CMD_FIRST);

  // Status priority at the checksum byte
  always_comb begin
    priority if (sum_add != SUM_GOOD) begin
      chk_status = ST_BAD_SUM;
    end else if (len_r != FRAME_LEN) begin
      chk_status = ST_BAD_LEN;
    end else if (!type_good_r) begin
      chk_status = ST_BAD_TYPE;
    end else if (!addr_good_r) begin
      chk_status = ST_BAD_ADDR;
    end else begin
      chk_status = ST_OK;
    end
  end

  // Next state and result
  always_comb begin
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    type_good_nxt = type_good_r;
    addr_good_nxt = addr_good_r;
    for (int i = 0; i < NUM_CMD; i++) begin
      cmd_nxt[i] = cmd_r[i];
    end
    emit              = 1'b0;
    result.status     = chk_status;
    result.length     = len_r;
    result.cmd_first  = cmd_r[0];
    result.cmd_second = cmd_r[1];
    result.cmd_third  = cmd_r[2];

    unique case (phase_r)
      PH_LEN_HI: begin
        len_nxt   = {rx_byte, 8'h00};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt = len_full;
        for (int i = 0; i < NUM_CMD; i++) begin
          cmd_nxt[i] = '0;
        end
        if (too_long) begin
          emit              = 1'b1;
          result.status     = ST_TOO_LONG;
          result.length     = len_full;
          result.cmd_first  = '0;
          result.cmd_second = '0;
          result.cmd_third  = '0;
          phase_nxt         = PH_SYNC;
        end else begin
          pos_nxt       = '0;
          sum_nxt       = '0;
          type_good_nxt = 1'b0;
          addr_good_nxt = 1'b1;
          phase_nxt     = (len_full == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt = sum_add;
        if (pos_r == 16'd0) begin
          type_good_nxt = (rx_byte == FRAME_TYPE);
        end else if (pos_r <= POS_ADDR_LAST) begin
          if (rx_byte != addr_want) begin
            addr_good_nxt = 1'b0;
          end
        end else if (pos_r >= POS_CMD_FIRST && pos_r <= POS_CMD_LAST) begin
          cmd_nxt[cmd_off] = rx_byte;
        end
        pos_nxt = pos_inc;
        if (pos_inc == len_r) begin
          phase_nxt = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        sum_nxt   = sum_add;
        emit      = 1'b1;
        phase_nxt = PH_SYNC;
      end
      default: begin
        phase_nxt = (rx_byte == START_BYTE) ? PH_LEN_HI : PH_SYNC;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC;
      len_r       <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      type_good_r <= 1'b0;
      addr_good_r <= 1'b0;
      for (int i = 0; i < NUM_CMD; i++) begin
        cmd_r[i] <= '0;
      end
    end else if (step) begin
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      type_good_r <= type_good_nxt;
      addr_good_r <= addr_good_nxt;
      for (int i = 0; i < NUM_CMD; i++) begin
        cmd_r[i] <= cmd_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  // A status only comes out of the length or checksum byte
  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (phase_r == PH_LEN_LO || phase_r == PH_CHECKSUM))
    else $error("status formed outside a frame end");

  // Checksum byte always returns the parser to sync
  a_chk_to_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_CHECKSUM) |=> phase_r == PH_SYNC)
    else $error("parser did not resync after checksum");

  // Position never runs past the length inside the payload
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> pos_r < len_r)
    else $error("payload position past frame length");

  // Oversize frames report no command bytes
  a_too_long_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && result.status == ST_TOO_LONG) |->
      (result.cmd_first == 8'h00 && result.cmd_second == 8'h00 &&
       result.cmd_third == 8'h00))
    else $error("oversize frame carried command bytes");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/afr_out_stage.sv @@
// ----------------------------------------------------------------------------
// afr_out_stage
// Result register: holds one status beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_out_stage
  import afr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire afr_result_t result,
  output logic             free,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output afr_result_t      out_beat
);

  logic        vld_r, vld_nxt;
  afr_result_t beat_r;

  // Slot is free when empty or when the held beat leaves this cycle
  assign free    = !vld_r || out_tready;
  assign vld_nxt = load || (vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= result;
    end
  end

  assign out_tvalid = vld_r;
  assign out_beat   = beat_r;

endmodule

`default_nettype wire

@@ test/api_frame_receiver_filter_unit_test.sv @@
// ----------------------------------------------------------------------------
// api_frame_receiver_filter_unit_test
// Self-checking bench for the API frame receiver and filter. Byte streams of
// well-formed, faulty, truncated and oversized frames, with noise between
// them, are pushed through the unit under varying idle and stall patterns.
// A scoreboard class tracks the parser from the accepted bytes and checks
// every status beat, field by field, in order.
// ----------------------------------------------------------------------------
module api_frame_receiver_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import afr_pkg::*;

  localparam int unsigned FRAME_MAX   = 128;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_PAUSE = 6;

  // Tracks parser state from accepted bytes and holds the expected status beats
  class FrameStatusBoard;
    afr_phase_t   phase;
    logic [15:0]  length;
    logic [15:0]  pos;
    afr_byte_t    sum;
    bit           type_ok;
    bit           addr_ok;
    afr_byte_t    cmds [NUM_CMD];
    logic [63:0]  source;
    afr_result_t  pending [$];
    int           errors;

    function new();
      phase   = PH_SYNC;
      length  = '0;
      pos     = '0;
      sum     = '0;
      type_ok = 1'b0;
      addr_ok = 1'b0;
      cmds    = '{default: '0};
      source  = '0;
      errors  = 0;
    endfunction

    function void load_source(logic [63:0] v);
      source = v;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void note_status(afr_status_t st);
      afr_result_t r;
      r.status     = st;
      r.length     = length;
      r.cmd_first  = cmds[0];
      r.cmd_second = cmds[1];
      r.cmd_third  = cmds[2];
      pending.push_back(r);
    endfunction

    // One accepted byte through the parser
    function void take_byte(afr_byte_t b);
      int          sh;
      afr_status_t st;
      case (phase)
        PH_LEN_HI: begin
          length = {b, 8'h00};
          phase  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length[7:0] = b;
          cmds        = '{default: '0};
          if (length > FRAME_MAX) begin
            phase = PH_SYNC;
            note_status(ST_TOO_LONG);
          end else begin
            pos     = '0;
            sum     = '0;
            type_ok = 1'b0;
            addr_ok = 1'b1;
            phase   = (length == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum = sum + b;
          if (pos == 16'd0) begin
            type_ok = (b == FRAME_TYPE);
          end else if (pos <= POS_ADDR_LAST) begin
            // address goes out most significant byte first
            sh = 8 * (8 - int'(pos));
            if (b != source[sh +: 8]) addr_ok = 1'b0;
          end else if (pos >= POS_CMD_FIRST && pos <= POS_CMD_LAST) begin
            cmds[pos - POS_CMD_FIRST] = b;
          end
          pos = pos + 16'd1;
          if (pos == length) phase = PH_CHECKSUM;
        end
        PH_CHECKSUM: begin
          sum   = sum + b;
          phase = PH_SYNC;
          if (sum != SUM_GOOD)          st = ST_BAD_SUM;
          else if (length != FRAME_LEN) st = ST_BAD_LEN;
          else if (!type_ok)            st = ST_BAD_TYPE;
          else if (!addr_ok)            st = ST_BAD_ADDR;
          else                          st = ST_OK;
          note_status(st);
        end
        default: begin
          phase = (b == START_BYTE) ? PH_LEN_HI : PH_SYNC;
        end
      endcase
    endfunction

    function void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s differs, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    // One status beat against the oldest expectation
    function void check_status(logic [2:0] user, logic [39:0] data);
      afr_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: status beat with none expected, expected none, actual status %0d data 0x%0h",
                 $time, user, data);
        return;
      end
      want = pending.pop_front();
      check_field("frame_status",   want.status,     user);
      check_field("frame_length",   want.length,     data[15:0]);
      check_field("command_first",  want.cmd_first,  data[23:16]);
      check_field("command_second", want.cmd_second, data[31:24]);
      check_field("command_third",  want.cmd_third,  data[39:32]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;

  FrameStatusBoard board;
  int          send_gap_pct;
  int          ready_stall_pct;
  bit          hold_off;
  logic [63:0] cur_source;
  int          bytes_sent;
  int          cycles;

  api_frame_receiver_filter_unit #(
    .MAX_LENGTH (FRAME_MAX)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("api_frame_receiver_filter_unit: mismatch");
      $finish;
    end
  end

  // Monitor: register writes, status beats and input beats at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) board.load_source(cfg_wr_data);
      if (out_tvalid && out_tready) board.check_status(out_tuser, out_tdata);
      if (in_tvalid && in_tready) board.take_byte(in_tdata);
    end
  end

  // Receiver side: random stalls, or a forced hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = !hold_off && ($urandom_range(99) >= ready_stall_pct);
    end
  end

  task automatic hold_receiver(input int n_cycles);
    hold_off = 1'b1;
    repeat (n_cycles) @(negedge clk);
    hold_off = 1'b0;
  endtask

  // One byte beat, with random idle cycles ahead of it
  task automatic send_byte(input afr_byte_t b);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Build and send one frame; keep < 0 sends it whole, else up to keep + 1 bytes
  task automatic send_frame(input logic [15:0] len, input bit bad_type, input bit bad_addr,
                            input bit bad_sum, input int keep, input int noise);
    afr_byte_t bytes [$];
    afr_byte_t b;
    afr_byte_t sum;
    int        bad_pos;
    bytes   = '{START_BYTE, len[15:8], len[7:0]};
    bad_pos = $urandom_range(1, 8);
    sum     = '0;
    if (len <= FRAME_MAX) begin
      for (int i = 0; i < int'(len); i++) begin
        b = $urandom;
        if (i == 0) begin
          if (!bad_type)            b = FRAME_TYPE;
          else if (b == FRAME_TYPE) b = b ^ 8'h01;
        end else if (i <= 8) begin
          b = cur_source[8 * (8 - i) +: 8];
          if (bad_addr && i == bad_pos) b = b ^ afr_byte_t'($urandom_range(1, 255));
        end
        bytes.push_back(b);
        sum = sum + b;
      end
      b = SUM_GOOD - sum;
      if (bad_sum) b = b ^ afr_byte_t'($urandom_range(1, 255));
      bytes.push_back(b);
    end
    if (keep >= 0) begin
      while (bytes.size() > keep + 1) void'(bytes.pop_back());
    end
    // noise ahead of the frame never holds a start byte
    repeat (noise) begin
      b = $urandom;
      if (b == START_BYTE) b = b ^ 8'h01;
      bytes.push_front(b);
    end
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  task automatic send_random_frame();
    int          pick;
    logic [15:0] len;
    int          keep;
    int          noise;
    pick = $urandom_range(99);
    if (pick < 68)      len = FRAME_LEN;
    else if (pick < 82) len = $urandom_range(20);
    else if (pick < 84) len = FRAME_MAX;
    else if (pick < 95) begin
      case ($urandom_range(2))
        0:       len = FRAME_MAX + 1;
        1:       len = 16'hFFFF;
        default: len = $urandom_range(FRAME_MAX + 1, 65535);
      endcase
    end else begin
      len = 16'd0;
    end
    keep  = ($urandom_range(99) < 5) ? $urandom_range(int'(len) + 2) : -1;
    noise = ($urandom_range(99) < 20) ? $urandom_range(1, 4) : 0;
    send_frame(len, $urandom_range(99) < 12, $urandom_range(99) < 12,
               $urandom_range(99) < 12, keep, noise);
  endtask

  task automatic wait_drain();
    in_tvalid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic write_source(input logic [63:0] v);
    wait_drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    cur_source  = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_phase(input int gap_pct, input int stall_pct, input int n_bytes);
    send_gap_pct    = gap_pct;
    ready_stall_pct = stall_pct;
    bytes_sent      = 0;
    while (bytes_sent < n_bytes) send_random_frame();
    wait_drain();
  endtask

  initial begin
    board           = new();
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    cur_source      = '0;
    send_gap_pct    = 0;
    ready_stall_pct = 0;
    hold_off        = 1'b0;
    bytes_sent      = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: ignored bytes, good frame at the reset address, just too long,
    // zero length
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(FRAME_LEN, 1'b0, 1'b0, 1'b0, -1, 0);
    send_frame(FRAME_MAX + 1, 1'b0, 1'b0, 1'b0, -1, 0);
    send_frame(16'd0, 1'b0, 1'b0, 1'b0, -1, 0);

    // Random frames across address settings and idle patterns
    write_source('1);
    run_phase(0, 0, 300);
    write_source({$urandom, $urandom});
    run_phase(82, 0, 250);
    write_source('0);
    run_phase(0, 82, 250);
    write_source({$urandom, $urandom});
    run_phase(24, 24, 300);

    // Back-pressure: receiver held off while the sender keeps offering
    write_source(64'h0013_A200_40A1_B2C3);
    fork
      hold_receiver(400);
      run_phase(0, 0, 200);
    join
    wait_drain();

    if (board.errors == 0) begin
      $display("api_frame_receiver_filter_unit: match");
    end else begin
      $display("api_frame_receiver_filter_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/afr_pkg.sv
hw/rtl/afr_in_stage.sv
hw/rtl/afr_parser.sv
hw/rtl/afr_out_stage.sv
hw/rtl/api_frame_receiver_filter_unit.sv
test/api_frame_receiver_filter_unit_test.sv
